// ===== rtl/avt_pkg.sv =====
// Shared types and constants of the affine vertex transform unit.
package avt_pkg;

	// Command codes carried in the input tuser
	localparam logic [2:0] CMD_WRITE     = 3'd0;
	localparam logic [2:0] CMD_VEC4      = 3'd1;
	localparam logic [2:0] CMD_POINT     = 3'd2;
	localparam logic [2:0] CMD_INVERSE   = 3'd3;
	localparam logic [2:0] CMD_TRANSLATE = 3'd4;
	localparam logic [2:0] CMD_SCALE     = 3'd5;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Beat layout
	localparam int S_DATA_W = 168;
	localparam int M_DATA_W = 128;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_VEC4,
		OP_POINT,
		OP_INVERSE,
		OP_TRANSLATE,
		OP_SCALE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  row_index;
		logic [1:0]  col_index;
		logic [31:0] element_value;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic [31:0] vw;
	} queue_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// ox sits in the lowest bits
	typedef struct packed {
		logic [31:0] ow;
		logic [31:0] oz;
		logic [31:0] oy;
		logic [31:0] ox;
	} result_t;

endpackage

// ===== rtl/avt_front.sv =====
// Front end: accepts input beats, decodes the command and feeds the queue.
module avt_front (
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [2:0]                s_tuser,
	input  logic [avt_pkg::S_DATA_W-1:0] s_tdata,
	input  avt_pkg::queue_status_t    q_status,
	output logic                      push,
	output avt_pkg::queue_entry_t     entry
);
	import avt_pkg::*;

	logic cmd_known;

	// Decode the command; unknown codes are accepted and dropped
	always_comb begin
		cmd_known = 1'b1;
		entry.op  = OP_WRITE;
		case (s_tuser)
			CMD_WRITE:     entry.op = OP_WRITE;
			CMD_VEC4:      entry.op = OP_VEC4;
			CMD_POINT:     entry.op = OP_POINT;
			CMD_INVERSE:   entry.op = OP_INVERSE;
			CMD_TRANSLATE: entry.op = OP_TRANSLATE;
			CMD_SCALE:     entry.op = OP_SCALE;
			default:       cmd_known = 1'b0;
		endcase

		// Unpack the payload
		entry.row_index     = s_tdata[1:0];
		entry.col_index     = s_tdata[3:2];
		entry.element_value = s_tdata[35:4];
		entry.vx            = s_tdata[67:36];
		entry.vy            = s_tdata[99:68];
		entry.vz            = s_tdata[131:100];
		entry.vw            = s_tdata[163:132];
	end

	assign s_tready = !q_status.full;
	assign push     = s_tvalid && s_tready && cmd_known;

endmodule

// ===== rtl/avt_queue.sv =====
// Short command queue that decouples the front end from the datapath.
module avt_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  avt_pkg::queue_entry_t  push_entry,
	input  logic                   pop,
	output avt_pkg::queue_entry_t  head,
	output avt_pkg::queue_status_t status
);
	import avt_pkg::*;

	queue_entry_t      entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = entries_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/avt_back.sv =====
// Back end: matrix store, product stage, sum and saturate logic, output register.
module avt_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  avt_pkg::queue_entry_t  head,
	input  avt_pkg::queue_status_t q_status,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output avt_pkg::result_t       result
);
	import avt_pkg::*;

	localparam int SHP_W = 64 - FRAC_BITS;
	localparam int SUM_W = SHP_W + 3;
	localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

	// Clamp a wide sum to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic [SUM_W-1:0] v);
		logic hi_all;
		logic hi_any;
		hi_all = &v[SUM_W-1:31];
		hi_any = |v[SUM_W-1:31];
		if (hi_all || !hi_any) begin
			sat32 = v[31:0];
		end else if (v[SUM_W-1]) begin
			sat32 = 32'h8000_0000;
		end else begin
			sat32 = 32'h7fff_ffff;
		end
	endfunction

	logic [3:0][3:0][31:0]     mat_q;
	logic signed [31:0]        opa [4][6];
	logic signed [31:0]        opb [4][6];
	logic signed [63:0]        full_prod [4][6];
	logic signed [SHP_W-1:0]   prod_s1 [4][6];
	logic                      valid_s1;
	op_t                       op_s1;
	logic                      valid_s2;
	result_t                   res_s2;
	logic signed [SUM_W-1:0]   sum [4];
	logic                      s1_modifier;
	logic                      s1_transform;
	logic                      s2_load;
	logic                      s1_advance;
	logic                      hazard;
	logic                      issue;

	// Stage control
	assign s1_modifier  = (op_s1 == OP_TRANSLATE) || (op_s1 == OP_SCALE);
	assign s1_transform = (op_s1 == OP_VEC4) || (op_s1 == OP_POINT) || (op_s1 == OP_INVERSE);
	assign s2_load      = !valid_s2 || m_tready;
	assign s1_advance   = s1_modifier || s2_load;
	assign hazard       = valid_s1 && s1_modifier;
	assign issue        = !q_status.empty && !hazard && (!valid_s1 || s1_advance);
	assign pop          = issue;

	// Route matrix elements and vector components to the multipliers
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int s = 0; s < 6; s++) begin
				opa[c][s] = '0;
				opb[c][s] = '0;
			end
		end
		case (head.op)
			OP_VEC4, OP_POINT, OP_TRANSLATE: begin
				for (int c = 0; c < 4; c++) begin
					if (head.op != OP_POINT || c < 3) begin
						opa[c][0] = head.vx; opb[c][0] = mat_q[0][c];
						opa[c][1] = head.vy; opb[c][1] = mat_q[1][c];
						opa[c][2] = head.vz; opb[c][2] = mat_q[2][c];
						opa[c][3] = (head.op == OP_VEC4) ? head.vw : ONE;
						opb[c][3] = mat_q[3][c];
					end
				end
			end
			OP_INVERSE: begin
				for (int c = 0; c < 3; c++) begin
					opa[c][0] = head.vx;     opb[c][0] = mat_q[c][0];
					opa[c][1] = head.vy;     opb[c][1] = mat_q[c][1];
					opa[c][2] = head.vz;     opb[c][2] = mat_q[c][2];
					opa[c][3] = mat_q[c][0]; opb[c][3] = mat_q[3][0];
					opa[c][4] = mat_q[c][1]; opb[c][4] = mat_q[3][1];
					opa[c][5] = mat_q[c][2]; opb[c][5] = mat_q[3][2];
				end
			end
			OP_SCALE: begin
				for (int c = 0; c < 4; c++) begin
					opa[c][0] = mat_q[0][c]; opb[c][0] = head.vx;
					opa[c][1] = mat_q[1][c]; opb[c][1] = head.vy;
					opa[c][2] = mat_q[2][c]; opb[c][2] = head.vz;
				end
			end
			default: begin
			end
		endcase
	end

	// Form every product in parallel
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int s = 0; s < 6; s++) begin
				full_prod[c][s] = opa[c][s] * opb[c][s];
			end
		end
	end

	// Register shifted products
	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1 <= head.op;
			for (int c = 0; c < 4; c++) begin
				for (int s = 0; s < 6; s++) begin
					prod_s1[c][s] <= SHP_W'(full_prod[c][s] >>> FRAC_BITS);
				end
			end
		end
	end

	// Sum each column; the inverse subtracts the translation terms
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum[c] = SUM_W'(prod_s1[c][0]) + SUM_W'(prod_s1[c][1]) + SUM_W'(prod_s1[c][2]);
			if (op_s1 == OP_INVERSE) begin
				sum[c] = sum[c] - (SUM_W'(prod_s1[c][3]) + SUM_W'(prod_s1[c][4])
					+ SUM_W'(prod_s1[c][5]));
			end else begin
				sum[c] = sum[c] + SUM_W'(prod_s1[c][3]);
			end
		end
	end

	// Update the matrix: element writes at issue, translate and scale at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					mat_q[r][c] <= (r == c) ? ONE : '0;
				end
			end
		end else begin
			if (issue && head.op == OP_WRITE) begin
				mat_q[head.row_index][head.col_index] <= head.element_value;
			end
			if (valid_s1 && op_s1 == OP_TRANSLATE) begin
				for (int c = 0; c < 4; c++) begin
					mat_q[3][c] <= sat32(sum[c]);
				end
			end
			if (valid_s1 && op_s1 == OP_SCALE) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 3; r++) begin
						mat_q[r][c] <= sat32(SUM_W'(prod_s1[c][r]));
					end
				end
			end
		end
	end

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue && head.op != OP_WRITE) begin
				valid_s1 <= 1'b1;
			end else if (s1_advance) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && s1_transform && s2_load) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Hold the saturated result for the output beat
	always_ff @(posedge clk) begin
		if (valid_s1 && s1_transform && s2_load) begin
			res_s2.ox <= sat32(sum[0]);
			res_s2.oy <= sat32(sum[1]);
			res_s2.oz <= sat32(sum[2]);
			res_s2.ow <= sat32(sum[3]);
		end
	end

	assign m_tvalid = valid_s2;
	assign result   = res_s2;

	// Nothing issues behind a pending matrix update
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && s1_modifier) |-> !issue)
		else $error("issue while a matrix update is pending");

	// A transform blocked by the output stays in the product stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && s1_transform && !s2_load) |=> (valid_s1 && $stable(op_s1)))
		else $error("transform lost while output stalled");

	// Row 3 changes only by a translate commit or an element write
	assert property (@(posedge clk) disable iff (!arst_n)
		(!(valid_s1 && op_s1 == OP_TRANSLATE) && !(issue && head.op == OP_WRITE))
		|=> $stable(mat_q[3]))
		else $error("row 3 changed without a translate or write");

endmodule

// ===== rtl/affine_vertex_transform_unit.sv =====
// Top level of the affine vertex transform unit.
//
// Holds a 4x4 row-major Q16.16 matrix and applies it to a stream of commands.
// Input beats arrive on s_tvalid/s_tready: s_tuser carries the command
// (write element, vec4, point, inverse point, translate, scale), s_tdata the
// element index, element value and vector components. Unknown command codes
// are accepted and dropped. Only transforms produce an output beat on
// m_tvalid/m_tready, carrying ox, oy, oz and ow (ow is zero for point and
// inverse point).
// A transform passes through the queue, the product stage and the output
// register before m_tvalid rises. Throughput: one beat per cycle for writes
// and transforms unless the queue or output stalls; a translate or scale
// holds the next command until its matrix update commits. The four-entry
// command queue lets the input keep going while the output is stalled; when
// it fills, s_tready drops.
// Reset sets the matrix to identity and empties the queue and pipeline.
module affine_vertex_transform_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cmd[2:0]
	input  logic [2:0]                    s_tuser,
	// row_index[1:0], col_index[3:2], element_value[35:4], vx[67:36],
	// vy[99:68], vz[131:100], vw[163:132], zero[167:164]
	input  logic [avt_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// ox[31:0], oy[63:32], oz[95:64], ow[127:96]
	output logic [avt_pkg::M_DATA_W-1:0]  m_tdata
);
	import avt_pkg::*;

	queue_entry_t  push_entry;
	queue_entry_t  head;
	queue_status_t q_status;
	result_t       result;
	logic          push;
	logic          pop;

	avt_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_status (q_status),
		.push     (push),
		.entry    (push_entry)
	);

	avt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	avt_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.result   (result)
	);

	assign m_tdata = result;

endmodule

// ===== tb/affine_vertex_transform_unit_tb.sv =====
// Testbench for the affine vertex transform unit: command stream, matrix predictor, result checks.
`timescale 1ns / 100ps

module affine_vertex_transform_unit_tb;
	import avt_pkg::*;

	localparam int FRAC           = 16;
	localparam int ITEM_TARGET    = 1750;
	localparam int RX_HOLD_CYCLES = 200;
	localparam int IDLE_PCT       = 37;
	localparam int Q_MIN          = 32'h8000_0000;
	localparam int Q_MAX          = 32'h7fff_ffff;
	localparam int Q_ONE          = 32'h0001_0000;

	// Spare command codes, accepted and dropped by the block
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	// Matrix predictor and queue of vertices still due on the output
	class vertex_scoreboard;
		int      mat [16];
		result_t vertex_q [$];
		int      errors;

		function new();
			for (int i = 0; i < 16; i++)
				mat[i] = ((i & 3) == (i >> 2)) ? Q_ONE : 0;
			errors = 0;
		endfunction

		// Exact product, floored by the fraction width
		function longint qmul(int a, int b);
			longint p;
			p = longint'(a) * longint'(b);
			return p >>> FRAC;
		endfunction

		function int sat(longint v);
			if (v > longint'(Q_MAX))
				return Q_MAX;
			if (v < -longint'(32'h8000_0000))
				return Q_MIN;
			return int'(v);
		endfunction

		function int outstanding();
			return vertex_q.size();
		endfunction

		// Apply one accepted command beat to the matrix or queue its vertex
		function void note_command(logic [2:0] cmd, logic [S_DATA_W-1:0] data);
			logic [1:0] row, col;
			int         ev, x, y, z, w;
			int         res [4];
			int         upd [16];
			longint     d;
			result_t    r;
			row = data[1:0];
			col = data[3:2];
			ev  = data[35:4];
			x   = data[67:36];
			y   = data[99:68];
			z   = data[131:100];
			w   = data[163:132];
			res = '{0, 0, 0, 0};
			upd = mat;
			case (cmd)
				CMD_WRITE: begin
					mat[{row, col}] = ev;
					return;
				end
				CMD_VEC4: begin
					for (int c = 0; c < 4; c++)
						res[c] = sat(qmul(x, mat[c]) + qmul(y, mat[4 + c]) +
							qmul(z, mat[8 + c]) + qmul(w, mat[12 + c]));
				end
				CMD_POINT: begin
					for (int c = 0; c < 3; c++)
						res[c] = sat(qmul(x, mat[c]) + qmul(y, mat[4 + c]) +
							qmul(z, mat[8 + c]) + longint'(mat[12 + c]));
				end
				CMD_INVERSE: begin
					for (int c = 0; c < 3; c++) begin
						d = qmul(mat[4 * c], mat[12]) + qmul(mat[4 * c + 1], mat[13]) +
							qmul(mat[4 * c + 2], mat[14]);
						res[c] = sat(qmul(x, mat[4 * c]) + qmul(y, mat[4 * c + 1]) +
							qmul(z, mat[4 * c + 2]) - d);
					end
				end
				CMD_TRANSLATE: begin
					for (int c = 0; c < 4; c++)
						upd[12 + c] = sat(longint'(mat[12 + c]) + qmul(x, mat[c]) +
							qmul(y, mat[4 + c]) + qmul(z, mat[8 + c]));
					mat = upd;
					return;
				end
				CMD_SCALE: begin
					for (int c = 0; c < 4; c++) begin
						upd[c]     = sat(qmul(mat[c], x));
						upd[4 + c] = sat(qmul(mat[4 + c], y));
						upd[8 + c] = sat(qmul(mat[8 + c], z));
					end
					mat = upd;
					return;
				end
				default: return;
			endcase
			r.ox = res[0];
			r.oy = res[1];
			r.oz = res[2];
			r.ow = res[3];
			vertex_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %h, got %h", name, want, got);
				errors++;
			end
		endfunction

		// Match one output beat against the oldest queued vertex
		function void check_result(logic [M_DATA_W-1:0] data);
			result_t got, want;
			got = data;
			if (vertex_q.size() == 0) begin
				$error("unexpected output beat %h", data);
				errors++;
				return;
			end
			want = vertex_q.pop_front();
			compare_field("ox", want.ox, got.ox);
			compare_field("oy", want.oy, got.oy);
			compare_field("oz", want.oz, got.oz);
			compare_field("ow", want.ow, got.ow);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [2:0]          s_tuser;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;

	vertex_scoreboard sb;
	int               items_sent;
	bit               tx_steady;
	bit               rx_steady;
	bit               rx_hold_req;
	bit               rx_hold_done;

	affine_vertex_transform_unit #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("affine_vertex_transform_unit_tb: FAIL");
		$finish;
	end

	// Note accepted commands and check output beats at each rising edge
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (s_tvalid && s_tready)
				sb.note_command(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// Drive output backpressure: random stalls, steady stretches, one long hold-off
	initial begin
		m_tready     = 1'b0;
		rx_hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req && !rx_hold_done) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_done = 1'b1;
			end
			m_tready <= !arst_n ? 1'b0 : (rx_steady || ($urandom_range(0, 99) >= IDLE_PCT));
		end
	end

	// Q16.16 operand with a mix of small, medium, full-range and edge values
	function automatic int rand_q();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5)
			return int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
		if (k < 7)
			return $urandom;
		if (k < 9)
			return int'($urandom) >>> $urandom_range(4, 12);
		case ($urandom_range(0, 5))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return 0;
			3: return -1;
			4: return Q_ONE;
			default: return -Q_ONE;
		endcase
	endfunction

	// Offer one command beat, with random gaps, and wait for it to be taken
	task automatic send_beat(logic [2:0] cmd, logic [1:0] row, logic [1:0] col,
		int ev, int x, int y, int z, int w);
		@(negedge clk);
		while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, w, z, y, x, ev, col, row};
		do @(posedge clk); while (!s_tready);
		if (cmd <= CMD_SCALE)
			items_sent++;
	endtask

	// Stop offering and wait until every queued vertex has come out
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic send_transform(logic [2:0] cmd);
		send_beat(cmd, 2'($urandom), 2'($urandom), $urandom,
			rand_q(), rand_q(), rand_q(), rand_q());
	endtask

	task automatic load_identity();
		for (int i = 0; i < 16; i++)
			send_beat(CMD_WRITE, i[3:2], i[1:0], ((i & 3) == (i >> 2)) ? Q_ONE : 0,
				$urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		int n;
		int kind;
		int near_one;
		sb          = new();
		items_sent  = 0;
		tx_steady   = 1'b0;
		rx_steady   = 1'b0;
		rx_hold_req = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tuser     = '0;
		s_tdata     = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: identity transforms at the extremes
		send_beat(CMD_VEC4, 0, 0, 0, Q_MIN, Q_MAX, 1, -1);
		send_beat(CMD_POINT, 0, 0, 0, Q_MAX, Q_MIN, -Q_ONE, Q_MAX);
		send_beat(CMD_INVERSE, 0, 0, 0, 1, 2, 3, 4);
		// Spare codes: dropped, no output
		send_beat(CMD_SPARE6, 2'd3, 2'd3, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
		send_beat(CMD_SPARE7, 2'd0, 2'd0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
		// Extreme elements to force saturation on outputs
		send_beat(CMD_WRITE, 2'd3, 2'd0, Q_MAX, 0, 0, 0, 0);
		send_beat(CMD_WRITE, 2'd3, 2'd1, Q_MIN, 0, 0, 0, 0);
		send_beat(CMD_WRITE, 2'd0, 2'd0, Q_MAX, 0, 0, 0, 0);
		send_beat(CMD_POINT, 0, 0, 0, Q_MAX, Q_MAX, 0, 0);
		send_beat(CMD_VEC4, 0, 0, 0, Q_MIN, 0, 0, Q_MIN);
		send_beat(CMD_INVERSE, 0, 0, 0, -1, -1, -1, 0);
		// Matrix updates with saturating amounts
		send_beat(CMD_TRANSLATE, 0, 0, 0, Q_ONE, -Q_ONE, Q_MAX, Q_MIN);
		send_beat(CMD_VEC4, 0, 0, 0, 1, 1, 1, 1);
		send_beat(CMD_SCALE, 0, 0, 0, Q_MIN, Q_MAX, 0, Q_MAX);
		send_beat(CMD_VEC4, 0, 0, 0, -Q_ONE, Q_ONE, Q_ONE, -Q_ONE);
		send_beat(CMD_WRITE, 2'd2, 2'd3, 32'h0001_8000, 0, 0, 0, 0);
		send_beat(CMD_WRITE, 2'd1, 2'd2, -32'h0000_8000, 0, 0, 0, 0);
		send_beat(CMD_TRANSLATE, 0, 0, 0, 0, 0, 0, 0);
		send_beat(CMD_SCALE, 0, 0, 0, 2 * Q_ONE, -32'h0000_8000, 1, 0);
		send_beat(CMD_POINT, 0, 0, 0, 32'h0003_4000, -32'h0002_0000, Q_ONE, 0);
		send_beat(CMD_INVERSE, 0, 0, 0, Q_MAX, Q_MIN, Q_MAX, 0);
		send_beat(CMD_VEC4, 0, 0, 0, $urandom, $urandom, $urandom, $urandom);
		drain();

		// Hold the output off while transforms keep coming, so the queue fills
		load_identity();
		tx_steady   = 1'b1;
		rx_hold_req = 1'b1;
		repeat (40)
			send_transform(3'(CMD_VEC4 + $urandom_range(0, 2)));
		tx_steady = 1'b0;
		drain();

		// Random: reload parts of the matrix, tweak it, then stream vertices
		while (items_sent < ITEM_TARGET) begin
			tx_steady = (items_sent >= 800 && items_sent < 1000);
			rx_steady = tx_steady;
			kind = $urandom_range(0, 99);
			if (kind < 4) begin
				load_identity();
			end else if (kind < 34) begin
				n = $urandom_range(1, 16);
				repeat (n)
					send_beat(CMD_WRITE, 2'($urandom), 2'($urandom), rand_q(),
						$urandom, $urandom, $urandom, $urandom);
			end else if (kind < 44) begin
				if ($urandom_range(0, 1)) begin
					send_beat(CMD_TRANSLATE, 2'($urandom), 2'($urandom), $urandom,
						rand_q(), rand_q(), rand_q(), $urandom);
				end else begin
					near_one = Q_ONE + int'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
					send_beat(CMD_SCALE, 2'($urandom), 2'($urandom), $urandom,
						($urandom_range(0, 3) == 0) ? rand_q() : near_one,
						($urandom_range(0, 3) == 0) ? rand_q() : near_one,
						($urandom_range(0, 3) == 0) ? rand_q() : near_one, $urandom);
				end
			end else if (kind < 49) begin
				send_beat($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7,
					2'($urandom), 2'($urandom),
					$urandom, $urandom, $urandom, $urandom, $urandom);
			end else if (kind < 50) begin
				drain();
			end
			n = $urandom_range(1, 12);
			repeat (n)
				send_transform(3'(CMD_VEC4 + $urandom_range(0, 2)));
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		// Let the pipeline empty and watch for stray beats
		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("affine_vertex_transform_unit_tb: PASS");
		else
			$display("affine_vertex_transform_unit_tb: FAIL");
		$finish;
	end

endmodule
